// ===== design/krje_pkg.sv =====
package krje_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int SLOT_W    = $clog2(KEY_SLOTS);
	localparam int LEN_W     = 7;
	localparam int CFG_IDX_W = 3;

	// Two header bytes precede the key slots
	localparam logic [LEN_W-1:0] MIN_REPORT_LEN = LEN_W'(2 + KEY_SLOTS);

	localparam logic [7:0] AXIS_LOW    = 8'h00;
	localparam logic [7:0] AXIS_CENTER = 8'h7f;
	localparam logic [7:0] AXIS_HIGH   = 8'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRE   = 3'd0,
		CFG_X      = 3'd1,
		CFG_Y      = 3'd2,
		CFG_SELECT = 3'd3,
		CFG_START  = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		EV_VERT  = 2'd0,
		EV_HORIZ = 2'd1,
		EV_BDOWN = 2'd2,
		EV_BUP   = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [LEN_W-1:0] report_length;
		logic [7:0]       key_slot_0;
		logic [7:0]       key_slot_1;
		logic [7:0]       key_slot_2;
		logic [7:0]       key_slot_3;
		logic [7:0]       key_slot_4;
		logic [7:0]       key_slot_5;
	} report_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] event_value;
		logic       last_event;
	} joy_event_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_write_t;

	typedef struct packed {
		logic [7:0] fire_code;
		logic [7:0] x_code;
		logic [7:0] y_code;
		logic [7:0] select_code;
		logic [7:0] start_code;
	} button_codes_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] kind;
		logic [7:0] value;
	} key_map_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic in_long;
		logic cand_valid;
		logic pend_valid;
		logic out_free;
		logic last_step;
	} status_t;

	function automatic key_map_t map_key(input logic [7:0] code, input logic press,
			input button_codes_t codes);
		key_map_t m;
		m.hit   = 1'b1;
		m.kind  = press ? EV_BDOWN : EV_BUP;
		m.value = AXIS_CENTER;
		if (code inside {8'h52, 8'h60, 8'h1a, 8'h0c}) begin
			m.kind  = EV_VERT;
			m.value = press ? AXIS_LOW : AXIS_CENTER;
		end else if (code inside {8'h5a, 8'h51, 8'h16, 8'h0e}) begin
			m.kind  = EV_VERT;
			m.value = press ? AXIS_HIGH : AXIS_CENTER;
		end else if (code inside {8'h50, 8'h5c, 8'h04, 8'h0d}) begin
			m.kind  = EV_HORIZ;
			m.value = press ? AXIS_LOW : AXIS_CENTER;
		end else if (code inside {8'h4f, 8'h5e, 8'h07, 8'h0f}) begin
			m.kind  = EV_HORIZ;
			m.value = press ? AXIS_HIGH : AXIS_CENTER;
		end else if (code inside {8'h62, 8'h2c, 8'h35, 8'h28, 8'h3a, 8'h05}) begin
			m.value = codes.fire_code;
		end else if (code == 8'h1b) begin
			m.value = codes.x_code;
		end else if (code == 8'h1c) begin
			m.value = codes.y_code;
		end else if (code == 8'h3b) begin
			m.value = codes.select_code;
		end else if (code == 8'h3c) begin
			m.value = codes.start_code;
		end else begin
			m.hit = 1'b0;
		end
		return m;
	endfunction

endpackage

// ===== design/krje_stream_if.sv =====
interface krje_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/krje_dp.sv =====
module krje_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  krje_pkg::report_t      report_in,
	input  logic                   cfg_we,
	input  krje_pkg::cfg_write_t   cfg_in,
	input  krje_pkg::cmd_t         cmd,
	output krje_pkg::status_t      status,
	input  logic                   out_ready,
	output logic                   out_valid,
	output krje_pkg::joy_event_t   out_data
);

	logic [7:0]                  held_q  [krje_pkg::KEY_SLOTS];
	logic [7:0]                  fresh_q [krje_pkg::KEY_SLOTS];
	logic [krje_pkg::SLOT_W-1:0] idx_q;
	logic                        phase_q;
	krje_pkg::button_codes_t     codes_q;
	logic                        pend_valid_q;
	logic [1:0]                  pend_kind_q;
	logic [7:0]                  pend_value_q;
	logic                        out_valid_q;
	krje_pkg::joy_event_t        out_q;

	logic [7:0]          cur_key;
	logic                present;
	krje_pkg::key_map_t  mapped;
	logic                cand_valid;
	logic                out_free;
	logic                last_step;
	logic                load_out;

	// Release phase walks held keys against the new report, press phase the reverse
	always_comb begin
		cur_key = phase_q ? fresh_q[idx_q] : held_q[idx_q];
		present = 1'b0;
		for (int i = 0; i < krje_pkg::KEY_SLOTS; i++) begin
			if ((phase_q ? held_q[i] : fresh_q[i]) == cur_key) begin
				present = 1'b1;
			end
		end
	end

	assign mapped     = krje_pkg::map_key(cur_key, phase_q, codes_q);
	assign cand_valid = (cur_key != 8'h00) && !present && mapped.hit;
	assign out_free   = !out_valid_q || out_ready;
	assign last_step  = phase_q && (idx_q == krje_pkg::SLOT_W'(krje_pkg::KEY_SLOTS - 1));
	assign load_out   = pend_valid_q && ((cmd.scan && cand_valid) || cmd.flush);

	assign status.in_long    = report_in.report_length >= krje_pkg::MIN_REPORT_LEN;
	assign status.cand_valid = cand_valid;
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;
	assign status.last_step  = last_step;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			phase_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			codes_q      <= '{fire_code: 8'd1, x_code: 8'd2, y_code: 8'd4,
				select_code: 8'd8, start_code: 8'd16};
			for (int i = 0; i < krje_pkg::KEY_SLOTS; i++) begin
				held_q[i] <= 8'h00;
			end
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				phase_q      <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (cmd.scan) begin
				if (idx_q == krje_pkg::SLOT_W'(krje_pkg::KEY_SLOTS - 1)) begin
					idx_q   <= '0;
					phase_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
				if (cand_valid) begin
					pend_valid_q <= 1'b1;
				end
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
				held_q       <= fresh_q;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_in.index)
					krje_pkg::CFG_FIRE:   codes_q.fire_code   <= cfg_in.data;
					krje_pkg::CFG_X:      codes_q.x_code      <= cfg_in.data;
					krje_pkg::CFG_Y:      codes_q.y_code      <= cfg_in.data;
					krje_pkg::CFG_SELECT: codes_q.select_code <= cfg_in.data;
					krje_pkg::CFG_START:  codes_q.start_code  <= cfg_in.data;
					default: ;
				endcase
			end
		end
	end

	// Hold one event back so the final one of a report can be flagged
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fresh_q[0] <= report_in.key_slot_0;
			fresh_q[1] <= report_in.key_slot_1;
			fresh_q[2] <= report_in.key_slot_2;
			fresh_q[3] <= report_in.key_slot_3;
			fresh_q[4] <= report_in.key_slot_4;
			fresh_q[5] <= report_in.key_slot_5;
		end
		if (cmd.scan && cand_valid) begin
			pend_kind_q  <= mapped.kind;
			pend_value_q <= mapped.value;
		end
		if (load_out) begin
			out_q.event_kind  <= pend_kind_q;
			out_q.event_value <= pend_value_q;
			out_q.last_event  <= cmd.flush;
		end
	end

endmodule

// ===== design/krje_ctrl.sv =====
module krje_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  krje_pkg::status_t status,
	output krje_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   advance;

	// A step stalls only when it must push the held event into a full output
	assign advance = !status.cand_valid || !status.pend_valid || status.out_free;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && status.in_long) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = advance;
				if (advance && status.last_step) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!status.pend_valid || status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/keyboard_report_to_joystick_events.sv =====
// Keyboard report to joystick events.
// report (sink): one boot keyboard report per request, a length and six key
//   slots. A report shorter than eight bytes is taken and dropped at once.
// joy_event (source): axis or button events, releases first then presses, both
//   in slot order; last_event marks the final event of a report.
// cfg (sink): button code writes, always ready, index 0 fire to 4 start.
// A full report is handled in order: an accept step, two passes of six slot
// steps (each slot compared combinationally against all six of the other set),
// and a final step to flag the last event and store the new keys. The next
// report is accepted the cycle after the final step. An event enters the output
// register at the slot step that finds the next mapped key, or at the final
// step for the last one, and can leave in the following cycle.
// One event is held back and one sits in the output register; a stalled
// receiver freezes the slot scan only when a third event needs to move.
// Reset clears the held keys and loads the default button codes 1, 2, 4, 8, 16.
module keyboard_report_to_joystick_events (
	input logic           clk,
	input logic           arst_n,
	krje_stream_if.sink   report,
	krje_stream_if.source joy_event,
	krje_stream_if.sink   cfg
);

	krje_pkg::cmd_t    cmd;
	krje_pkg::status_t status;

	assign cfg.ready = 1'b1;

	krje_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (report.valid),
		.in_ready (report.ready),
		.status   (status),
		.cmd      (cmd)
	);

	krje_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.report_in (report.payload),
		.cfg_we    (cfg.valid),
		.cfg_in    (cfg.payload),
		.cmd       (cmd),
		.status    (status),
		.out_ready (joy_event.ready),
		.out_valid (joy_event.valid),
		.out_data  (joy_event.payload)
	);

	a_long_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.ready &&
			report.payload.report_length >= krje_pkg::MIN_REPORT_LEN) |=> !report.ready)
		else $error("report accepted while a long report is being scanned");

	a_short_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.ready &&
			report.payload.report_length < krje_pkg::MIN_REPORT_LEN) |=> report.ready)
		else $error("short report was not dropped");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> !cmd.scan && !cmd.load)
		else $error("flush overlaps another command");

endmodule

// ===== tb/sv/keyboard_report_to_joystick_events_test.sv =====
module keyboard_report_to_joystick_events_test;

	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_REPORTS = 60;

	localparam logic [7:0] MAPPED_KEYS [26] = '{
		8'h52, 8'h60, 8'h1a, 8'h0c, 8'h5a, 8'h51, 8'h16, 8'h0e,
		8'h50, 8'h5c, 8'h04, 8'h0d, 8'h4f, 8'h5e, 8'h07, 8'h0f,
		8'h62, 8'h2c, 8'h35, 8'h28, 8'h3a, 8'h05,
		8'h1b, 8'h1c, 8'h3b, 8'h3c
	};

	class key_event_tracker;
		logic [7:0]              held [krje_pkg::KEY_SLOTS];
		krje_pkg::button_codes_t codes;
		krje_pkg::joy_event_t    pending_events [$];
		int                      mismatches;
		int                      events_seen;
		int                      reports_taken;
		int                      short_reports;
		int                      code_writes;

		function new();
			foreach (held[i]) held[i] = 8'h00;
			codes = '{fire_code: 8'd1, x_code: 8'd2, y_code: 8'd4,
				select_code: 8'd8, start_code: 8'd16};
		endfunction

		function bit holds(input logic [7:0] set [krje_pkg::KEY_SLOTS],
				input logic [7:0] code);
			foreach (set[i])
				if (set[i] == code)
					return 1'b1;
			return 1'b0;
		endfunction

		// Map one key change to its event; unmapped keys give nothing.
		function bit classify(input logic [7:0] code, input bit press,
				output krje_pkg::joy_event_t ev);
			bit button;
			button = 1'b1;
			ev = '0;
			case (code)
				8'h52, 8'h60, 8'h1a, 8'h0c: begin
					button = 1'b0;
					ev.event_kind = krje_pkg::EV_VERT;
					ev.event_value = press ? krje_pkg::AXIS_LOW : krje_pkg::AXIS_CENTER;
				end
				8'h5a, 8'h51, 8'h16, 8'h0e: begin
					button = 1'b0;
					ev.event_kind = krje_pkg::EV_VERT;
					ev.event_value = press ? krje_pkg::AXIS_HIGH : krje_pkg::AXIS_CENTER;
				end
				8'h50, 8'h5c, 8'h04, 8'h0d: begin
					button = 1'b0;
					ev.event_kind = krje_pkg::EV_HORIZ;
					ev.event_value = press ? krje_pkg::AXIS_LOW : krje_pkg::AXIS_CENTER;
				end
				8'h4f, 8'h5e, 8'h07, 8'h0f: begin
					button = 1'b0;
					ev.event_kind = krje_pkg::EV_HORIZ;
					ev.event_value = press ? krje_pkg::AXIS_HIGH : krje_pkg::AXIS_CENTER;
				end
				8'h62, 8'h2c, 8'h35, 8'h28, 8'h3a, 8'h05: ev.event_value = codes.fire_code;
				8'h1b: ev.event_value = codes.x_code;
				8'h1c: ev.event_value = codes.y_code;
				8'h3b: ev.event_value = codes.select_code;
				8'h3c: ev.event_value = codes.start_code;
				default: return 1'b0;
			endcase
			if (button)
				ev.event_kind = press ? krje_pkg::EV_BDOWN : krje_pkg::EV_BUP;
			return 1'b1;
		endfunction

		function void take_report(input krje_pkg::report_t r);
			logic [7:0] fresh [krje_pkg::KEY_SLOTS];
			krje_pkg::joy_event_t batch [$];
			krje_pkg::joy_event_t ev;
			reports_taken++;
			if (r.report_length < krje_pkg::MIN_REPORT_LEN) begin
				short_reports++;
				return;
			end
			fresh = '{r.key_slot_0, r.key_slot_1, r.key_slot_2,
				r.key_slot_3, r.key_slot_4, r.key_slot_5};
			// releases first, then presses, both in slot order
			foreach (held[i])
				if (held[i] != 8'h00 && !holds(fresh, held[i]) && classify(held[i], 1'b0, ev))
					batch.push_back(ev);
			foreach (fresh[i])
				if (fresh[i] != 8'h00 && !holds(held, fresh[i]) && classify(fresh[i], 1'b1, ev))
					batch.push_back(ev);
			held = fresh;
			if (batch.size() > 0)
				batch[batch.size() - 1].last_event = 1'b1;
			foreach (batch[i])
				pending_events.push_back(batch[i]);
		endfunction

		function void set_code(input krje_pkg::cfg_write_t w);
			code_writes++;
			case (w.index)
				krje_pkg::CFG_FIRE:   codes.fire_code = w.data;
				krje_pkg::CFG_X:      codes.x_code = w.data;
				krje_pkg::CFG_Y:      codes.y_code = w.data;
				krje_pkg::CFG_SELECT: codes.select_code = w.data;
				krje_pkg::CFG_START:  codes.start_code = w.data;
				default: ;
			endcase
		endfunction

		function void match_event(input krje_pkg::joy_event_t got);
			krje_pkg::joy_event_t want;
			events_seen++;
			if (pending_events.size() == 0) begin
				$error("unexpected event: event_kind %0d, event_value %02h, last_event %0d",
					got.event_kind, got.event_value, got.last_event);
				mismatches++;
				return;
			end
			want = pending_events.pop_front();
			if (got.event_kind !== want.event_kind) begin
				$error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
				mismatches++;
			end
			if (got.event_value !== want.event_value) begin
				$error("event_value: expected %02h, actual %02h", want.event_value, got.event_value);
				mismatches++;
			end
			if (got.last_event !== want.last_event) begin
				$error("last_event: expected %0d, actual %0d", want.last_event, got.last_event);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	krje_stream_if #(.T(krje_pkg::report_t))    report_ch ();
	krje_stream_if #(.T(krje_pkg::joy_event_t)) joy_ch ();
	krje_stream_if #(.T(krje_pkg::cfg_write_t)) cfg_ch ();

	keyboard_report_to_joystick_events uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report_ch.sink),
		.joy_event (joy_ch.source),
		.cfg       (cfg_ch.sink)
	);

	key_event_tracker tracker = new();

	logic [7:0] last_slots [krje_pkg::KEY_SLOTS];
	int         idle_odds;
	int         stall_left = 0;
	int         quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (report_ch.valid && report_ch.ready)
				tracker.take_report(report_ch.payload);
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.set_code(cfg_ch.payload);
			if (joy_ch.valid && joy_ch.ready)
				tracker.match_event(joy_ch.payload);
		end
	end

	// Stall the event receiver in bursts while idling is allowed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				joy_ch.ready <= 1'b0;
			end else if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				joy_ch.ready <= 1'b0;
			end else begin
				joy_ch.ready <= 1'b1;
			end
		end else begin
			joy_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((report_ch.valid && report_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
					|| (joy_ch.valid && joy_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("no handshake for %0d cycles, %0d events still due",
					IDLE_LIMIT, tracker.pending_events.size());
				$display("keyboard_report_to_joystick_events_test: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1: return 8'h00;
			2: return 8'($urandom_range(0, 255));
			default: return MAPPED_KEYS[$urandom_range(0, 25)];
		endcase
	endfunction

	function automatic logic [krje_pkg::LEN_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0: return krje_pkg::LEN_W'($urandom_range(0, 7));
			1: return krje_pkg::LEN_W'($urandom_range(65, 127));
			default: return krje_pkg::LEN_W'($urandom_range(8, 64));
		endcase
	endfunction

	task automatic send_slots(input logic [krje_pkg::LEN_W-1:0] len,
			input logic [7:0] s [krje_pkg::KEY_SLOTS]);
		krje_pkg::report_t r;
		r.report_length = len;
		r.key_slot_0 = s[0];
		r.key_slot_1 = s[1];
		r.key_slot_2 = s[2];
		r.key_slot_3 = s[3];
		r.key_slot_4 = s[4];
		r.key_slot_5 = s[5];
		last_slots = s;
		if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			report_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		// valid is left high after the handshake so back-to-back requests keep it asserted
		report_ch.valid <= 1'b1;
		report_ch.payload <= r;
		@(posedge clk);
		while (!report_ch.ready) @(posedge clk);
	endtask

	task automatic send_keys(input logic [krje_pkg::LEN_W-1:0] len,
			input logic [7:0] k0, k1, k2, k3, k4, k5);
		send_slots(len, '{k0, k1, k2, k3, k4, k5});
	endtask

	task automatic send_random_report();
		logic [7:0] s [krje_pkg::KEY_SLOTS];
		foreach (s[i])
			s[i] = ($urandom_range(0, 2) == 0) ? last_slots[i] : pick_key();
		send_slots(pick_length(), s);
	endtask

	// Drop the report valid, wait for every due event, then let the block go idle.
	task automatic settle();
		report_ch.valid <= 1'b0;
		while (tracker.pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_codes(input logic [7:0] fire, xc, yc, sel, st, input bit add_unused);
		krje_pkg::cfg_write_t w [$];
		if (add_unused)
			for (int i = krje_pkg::CFG_START + 1; i < 2 ** krje_pkg::CFG_IDX_W; i++)
				w.push_back('{index: krje_pkg::CFG_IDX_W'(i),
					data: 8'($urandom_range(0, 255))});
		w.push_back('{index: krje_pkg::CFG_FIRE, data: fire});
		w.push_back('{index: krje_pkg::CFG_X, data: xc});
		w.push_back('{index: krje_pkg::CFG_Y, data: yc});
		w.push_back('{index: krje_pkg::CFG_SELECT, data: sel});
		w.push_back('{index: krje_pkg::CFG_START, data: st});
		foreach (w[i]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.payload <= w[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		idle_odds = 3;
		foreach (last_slots[i]) last_slots[i] = 8'h00;
		report_ch.valid <= 1'b0;
		report_ch.payload <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short reports, then the axis keys, buttons, duplicates and unmapped codes
		send_keys(0, 8'h52, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00);
		send_keys(7, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		send_keys(8, 8'h52, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00);
		send_keys(127, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_keys(8, 8'h5a, 8'h4f, 8'h62, 8'h1b, 8'h1c, 8'h3b);
		send_keys(64, 8'h3c, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h00);
		send_keys(8, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		send_keys(9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_keys(8, 8'h2c, 8'h2c, 8'h35, 8'h28, 8'h3a, 8'h05);
		send_keys(8, 8'h60, 8'h1a, 8'h0c, 8'h51, 8'h16, 8'h0e);
		send_keys(65, 8'h5c, 8'h04, 8'h0d, 8'h5e, 8'h07, 8'h0f);
		send_keys(8, 8'h01, 8'h80, 8'h55, 8'haa, 8'h7f, 8'hfe);
		send_keys(8, 8'h62, 8'h62, 8'h1b, 8'h1c, 8'h3b, 8'h3c);
		send_keys(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		settle();
		load_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		send_keys(8, 8'h05, 8'h1b, 8'h1c, 8'h3b, 8'h3c, 8'h00);
		send_keys(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		settle();
		load_codes(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
		send_keys(8, 8'h3c, 8'h3b, 8'h1c, 8'h1b, 8'h28, 8'h00);
		send_keys(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			load_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), p == 2);
			case (p % 3)
				0: idle_odds = 2;
				1: idle_odds = 6;
				default: idle_odds = 0;
			endcase
			// hold both sides busy for the final phase
			if (p == RANDOM_PHASES - 1)
				idle_odds = 0;
			repeat (PHASE_REPORTS) send_random_report();
		end

		settle();
		$display("%0d reports driven (%0d short), %0d register writes",
			tracker.reports_taken, tracker.short_reports, tracker.code_writes);
		$display("%0d joystick events checked against the predicted sequence",
			tracker.events_seen);
		if (tracker.mismatches == 0 && tracker.pending_events.size() == 0)
			$display("keyboard_report_to_joystick_events_test: PASS");
		else
			$display("keyboard_report_to_joystick_events_test: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/krje_pkg.sv
design/krje_stream_if.sv
design/krje_dp.sv
design/krje_ctrl.sv
design/keyboard_report_to_joystick_events.sv
tb/sv/keyboard_report_to_joystick_events_test.sv
